// ===== rtl/directed_cycle_detect_assert.svh =====
// Assertion macros used by the checker of the cycle detector.
`ifndef DIRECTED_CYCLE_DETECT_ASSERT_SVH
`define DIRECTED_CYCLE_DETECT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define DCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define DCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/dcd_pkg.sv =====
package dcd_pkg;

  // Fixed widths of the request and register fields.
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned ROW_IDX_W = 4;
  localparam int unsigned CNT_IN_W  = 5;

  // Node count after reset.
  localparam logic [CNT_IN_W-1:0] NODE_COUNT_RESET = 5'd16;

  // Commands from the top level to the search sequencer.
  typedef struct packed {
    logic start;  // last row accepted, begin the search
    logic take;   // output register can take a result
  } walk_ctl_t;

  // Status of the search sequencer.
  typedef struct packed {
    logic idle;
    logic done;
    logic has_cycle;
  } walk_stat_t;

endpackage

// ===== rtl/dcd_adj_store.sv =====
module dcd_adj_store #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                            clk_i,
  input  logic                            wr_i,
  input  logic [dcd_pkg::ROW_IDX_W-1:0]   row_index_i,
  input  logic [dcd_pkg::ROW_W-1:0]       row_edges_i,
  input  logic                            rd_i,
  input  logic [$clog2(MAX_NODES)-1:0]    rd_addr_i,
  output logic [dcd_pkg::ROW_W-1:0]       rd_data_o
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CMP_W  = 7;

  logic [dcd_pkg::ROW_W-1:0] mem [MAX_NODES];
  logic [dcd_pkg::ROW_W-1:0] rd_data_q;
  logic                      row_in_range;

  // Rows at or above the node capacity are dropped.
  assign row_in_range = CMP_W'(row_index_i) < CMP_W'(MAX_NODES);

  // Adjacency memory: one write port from the input, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i && row_in_range) begin
      mem[NODE_W'(row_index_i)] <= row_edges_i;
    end
    if (rd_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dcd_walker.sv =====
module dcd_walker #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dcd_pkg::walk_ctl_t                ctl_i,
  input  logic [dcd_pkg::CNT_IN_W-1:0]      node_count_i,
  output logic                              adj_rd_o,
  output logic [$clog2(MAX_NODES)-1:0]      adj_addr_o,
  input  logic [dcd_pkg::ROW_W-1:0]         adj_data_i,
  output dcd_pkg::walk_stat_t               stat_o
);

  localparam int unsigned NODE_W  = $clog2(MAX_NODES);
  localparam int unsigned CNT_W   = $clog2(MAX_NODES + 1);
  localparam int unsigned CMP_W   = ((CNT_W > dcd_pkg::CNT_IN_W) ? CNT_W : dcd_pkg::CNT_IN_W) + 1;
  localparam int unsigned ENTRY_W = NODE_W + CNT_W + dcd_pkg::ROW_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          start_q, start_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic [CNT_W-1:0]          k_q, k_d;
  logic [CNT_W-1:0]          depth_q, depth_d;
  logic [NODE_W-1:0]         u_q, u_d;
  logic [dcd_pkg::ROW_W-1:0] row_q, row_d;
  logic [MAX_NODES-1:0]      grey_q, grey_d;
  logic [MAX_NODES-1:0]      black_q, black_d;
  logic                      cycle_q, cycle_d;

  logic [CNT_W-1:0]          n_c;
  logic [CMP_W-1:0]          k_ext;
  logic                      edge_c;
  logic [NODE_W-1:0]         k_node;
  logic [NODE_W-1:0]         start_node;
  logic [CNT_W-1:0]          depth_m1;
  logic [CNT_W-1:0]          depth_m2;
  logic [CNT_W-1:0]          k_inc;

  logic                      st_we, st_re;
  logic [NODE_W-1:0]         st_waddr, st_raddr;
  logic [ENTRY_W-1:0]        st_wdata;
  logic [ENTRY_W-1:0]        st_rdata_q;
  logic [ENTRY_W-1:0]        stack_mem [MAX_NODES];

  // Node count clamped to the capacity.
  always_comb begin
    if (CMP_W'(node_count_i) > CMP_W'(MAX_NODES)) begin
      n_c = CNT_W'(MAX_NODES);
    end else begin
      n_c = CNT_W'(node_count_i);
    end
  end

  // Edge test on the cached row of the node on top of the stack.
  assign k_ext      = CMP_W'(k_q);
  assign edge_c     = (k_ext < CMP_W'(dcd_pkg::ROW_W)) && row_q[k_ext[3:0]];
  assign k_node     = k_q[NODE_W-1:0];
  assign start_node = start_q[NODE_W-1:0];
  assign depth_m1   = depth_q - CNT_W'(1);
  assign depth_m2   = depth_q - CNT_W'(2);
  assign k_inc      = k_q + CNT_W'(1);

  // Search sequencer. The top of the stack lives in registers; the entries
  // below it live in the stack memory together with their cached rows.
  always_comb begin
    state_d    = state_q;
    start_d    = start_q;
    n_d        = n_q;
    k_d        = k_q;
    depth_d    = depth_q;
    u_d        = u_q;
    row_d      = row_q;
    grey_d     = grey_q;
    black_d    = black_q;
    cycle_d    = cycle_q;
    adj_rd_o   = 1'b0;
    adj_addr_o = k_node;
    st_we      = 1'b0;
    st_waddr   = depth_m1[NODE_W-1:0];
    st_wdata   = {u_q, k_inc, row_q};
    st_re      = 1'b0;
    st_raddr   = depth_m2[NODE_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          start_d = '0;
          n_d     = n_c;
          depth_d = '0;
          grey_d  = '0;
          black_d = '0;
          cycle_d = 1'b0;
          state_d = S_START;
        end
      end

      S_START: begin
        if (start_q >= n_q) begin
          cycle_d = 1'b0;
          state_d = S_RESULT;
        end else if (grey_q[start_node] || black_q[start_node]) begin
          start_d = start_q + CNT_W'(1);
        end else begin
          grey_d[start_node] = 1'b1;
          u_d        = start_node;
          k_d        = '0;
          depth_d    = CNT_W'(1);
          adj_rd_o   = 1'b1;
          adj_addr_o = start_node;
          state_d    = S_FETCH;
        end
      end

      S_FETCH: begin
        row_d   = adj_data_i;
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (k_q >= n_q) begin
          // All edges of the top node checked: it turns black.
          grey_d[u_q]  = 1'b0;
          black_d[u_q] = 1'b1;
          depth_d      = depth_m1;
          if (depth_q == CNT_W'(1)) begin
            start_d = start_q + CNT_W'(1);
            state_d = S_START;
          end else begin
            st_re   = 1'b1;
            state_d = S_POP;
          end
        end else begin
          k_d = k_inc;
          if (edge_c && !black_q[k_node]) begin
            if (grey_q[k_node] || (depth_q >= CNT_W'(MAX_NODES))) begin
              // Back edge to a node on the walk.
              cycle_d = 1'b1;
              depth_d = '0;
              state_d = S_RESULT;
            end else begin
              // Descend: save the current top and fetch the new node's row.
              st_we          = 1'b1;
              grey_d[k_node] = 1'b1;
              u_d            = k_node;
              k_d            = '0;
              depth_d        = depth_q + CNT_W'(1);
              adj_rd_o       = 1'b1;
              state_d        = S_FETCH;
            end
          end
        end
      end

      S_POP: begin
        u_d     = st_rdata_q[ENTRY_W-1 -: NODE_W];
        k_d     = st_rdata_q[dcd_pkg::ROW_W +: CNT_W];
        row_d   = st_rdata_q[dcd_pkg::ROW_W-1:0];
        state_d = S_SCAN;
      end

      S_RESULT: begin
        if (ctl_i.take) begin
          depth_d = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      cycle_q <= 1'b0;
      grey_q  <= '0;
      black_q <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      cycle_q <= cycle_d;
      grey_q  <= grey_d;
      black_q <= black_d;
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    n_q     <= n_d;
    k_q     <= k_d;
    u_q     <= u_d;
    row_q   <= row_d;
  end

  // Stack memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= stack_mem[st_raddr];
    end
  end

  assign stat_o.idle      = (state_q == S_IDLE);
  assign stat_o.done      = (state_q == S_RESULT);
  assign stat_o.has_cycle = cycle_q;

endmodule

// ===== rtl/directed_cycle_detect.sv =====
// Directed cycle detector: row requests are taken back to back while the sequencer is idle.
// The last row starts a depth-first search over the N nodes in use: row fetches, edge checks,
// descents and returns through the stack and start-node steps, ending in a result state;
// the result then passes to the output register.
// Reset clears the sequencer, the node colors and the output register and sets
// the node count to 16; adjacency rows are kept undefined until written.
module directed_cycle_detect #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dcd_pkg::CNT_IN_W-1:0]  cfg_node_count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dcd_pkg::ROW_IDX_W-1:0] row_index_i,
  input  logic [dcd_pkg::ROW_W-1:0]     row_edges_i,
  input  logic                          last_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          has_cycle_o
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);

  logic [dcd_pkg::CNT_IN_W-1:0] node_count_q;
  logic                         out_valid_q;
  logic                         has_cycle_q;
  logic                         in_accept;
  dcd_pkg::walk_ctl_t           ctl;
  dcd_pkg::walk_stat_t          stat;
  logic                         adj_rd;
  logic [NODE_W-1:0]            adj_addr;
  logic [dcd_pkg::ROW_W-1:0]    adj_data;

  // Node count register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dcd_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_node_count_i;
    end
  end

  // Row requests are taken only while the sequencer is idle, not while it searches or holds a result.
  assign in_ready_o = stat.idle;
  assign in_accept  = in_valid_i && in_ready_o;
  assign ctl.start  = in_accept && last_row_i;
  assign ctl.take   = !out_valid_q || out_ready_i;

  dcd_adj_store #(
    .MAX_NODES (MAX_NODES)
  ) u_adj (
    .clk_i       (clk_i),
    .wr_i        (in_accept),
    .row_index_i (row_index_i),
    .row_edges_i (row_edges_i),
    .rd_i        (adj_rd),
    .rd_addr_i   (adj_addr),
    .rd_data_o   (adj_data)
  );

  dcd_walker #(
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .node_count_i (node_count_q),
    .adj_rd_o     (adj_rd),
    .adj_addr_o   (adj_addr),
    .adj_data_i   (adj_data),
    .stat_o       (stat)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done && ctl.take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && ctl.take) begin
      has_cycle_q <= stat.has_cycle;
    end
  end

  assign out_valid_o = out_valid_q;
  assign has_cycle_o = has_cycle_q;

endmodule

// ===== rtl/dcd_checker.sv =====
`include "directed_cycle_detect_assert.svh"

module dcd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic last_row_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic has_cycle_o
);

  // A stalled result holds its value.
  `DCD_ASSERT_RST(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(has_cycle_o), "result changed while stalled")

  // The last row starts the search, which blocks further row requests.
  `DCD_ASSERT_RST(a_last_starts, in_valid_i && in_ready_o && last_row_i |=> !in_ready_o, "search did not start on the last row")

  // Any other row leaves the block ready for the next one.
  `DCD_ASSERT_RST(a_row_ready, in_valid_i && in_ready_o && !last_row_i |=> in_ready_o, "block stalled after a plain row")

  // A new result only appears at the end of a search.
  `DCD_ASSERT_RST(a_result_after_search, $rose(out_valid_o) |-> !$past(in_ready_o), "result without a search")

  // Reset empties the output register.
  `DCD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind directed_cycle_detect dcd_checker u_dcd_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ROW_W         = dcd_pkg::ROW_W;
  localparam int unsigned ROW_IDX_W     = dcd_pkg::ROW_IDX_W;
  localparam int unsigned CNT_IN_W      = dcd_pkg::CNT_IN_W;
  localparam int unsigned MAX_NODES     = 16;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned PHASE_ITEMS   = 220;
  localparam int unsigned NUM_PHASES    = 9;

  typedef enum logic [1:0] {
    COLOR_WHITE,
    COLOR_GREY,
    COLOR_BLACK
  } node_color_e;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_W-1:0]     edges;
    logic                 last;
  } row_req_t;

  // Clock, reset and the inputs of the block, all known from time zero.
  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_valid_i      = 1'b0;
  logic [CNT_IN_W-1:0]  cfg_node_count_i = '0;
  logic                 in_valid_i       = 1'b0;
  logic [ROW_IDX_W-1:0] row_index_i      = '0;
  logic [ROW_W-1:0]     row_edges_i      = '0;
  logic                 last_row_i       = 1'b0;
  logic                 out_ready_i      = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 has_cycle_o;

  // Pending row requests, expected search outcomes and the graph as the block holds it.
  row_req_t            row_q[$];
  logic                cycle_flag_q[$];
  logic [ROW_W-1:0]    adj_model [MAX_NODES];
  logic [CNT_IN_W-1:0] node_count_model = dcd_pkg::NODE_COUNT_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_go = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned error_count = 0;

  int nc_plan [NUM_PHASES] = '{16, 1, 0, 31, 17, 8, -1, 16, 3};

  directed_cycle_detect #(
    .MAX_NODES(MAX_NODES)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_node_count_i(cfg_node_count_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .row_index_i     (row_index_i),
    .row_edges_i     (row_edges_i),
    .last_row_i      (last_row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .has_cycle_o     (has_cycle_o)
  );

  always #1 clk_i = ~clk_i;

  // Three-colour depth-first search over the nodes in use, with an explicit stack.
  function automatic logic predict_cycle();
    node_color_e              color [MAX_NODES];
    logic [ROW_IDX_W-1:0]     stk_node [MAX_NODES];
    logic [CNT_IN_W-1:0]      stk_next [MAX_NODES];
    int unsigned              n_used;
    int unsigned              depth;
    int unsigned              top;
    int unsigned              s;
    logic [ROW_IDX_W-1:0]     u;
    logic [CNT_IN_W-1:0]      k;
    n_used = (node_count_model > MAX_NODES) ? MAX_NODES : node_count_model;
    foreach (color[i]) color[i] = COLOR_WHITE;
    for (s = 0; s < n_used; s++) begin
      if (color[s] == COLOR_WHITE) begin
        color[s] = COLOR_GREY;
        stk_node[0] = s[ROW_IDX_W-1:0];
        stk_next[0] = '0;
        depth = 1;
        while (depth > 0) begin
          top = depth - 1;
          u = stk_node[top];
          k = stk_next[top];
          if (k >= n_used) begin
            color[u] = COLOR_BLACK;
            depth--;
          end else begin
            stk_next[top] = k + 1'b1;
            if (adj_model[u][k[ROW_IDX_W-1:0]]) begin
              // An edge back into the current path closes a cycle.
              if (color[k[ROW_IDX_W-1:0]] == COLOR_GREY) return 1'b1;
              if (color[k[ROW_IDX_W-1:0]] == COLOR_WHITE) begin
                color[k[ROW_IDX_W-1:0]] = COLOR_GREY;
                stk_node[depth] = k[ROW_IDX_W-1:0];
                stk_next[depth] = '0;
                depth++;
              end
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_row(input int unsigned idx, input logic [ROW_W-1:0] edges,
                          input logic last);
    row_req_t req;
    req.row   = idx[ROW_IDX_W-1:0];
    req.edges = edges;
    req.last  = last;
    row_q.push_back(req);
  endtask

  // One graph: either a full rewrite as a DAG (sometimes with a back edge),
  // or a few rows changed on top of the previous graph. The final row starts the search.
  task automatic push_graph(output int unsigned pushed);
    int unsigned      n_eff;
    int unsigned      mode;
    int unsigned      rows_used;
    int unsigned      order [MAX_NODES];
    int unsigned      rank [MAX_NODES];
    int unsigned      j;
    int unsigned      tmp;
    int unsigned      r;
    int unsigned      cnt;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] edges;
    row_req_t         rows [MAX_NODES];
    n_eff = (node_count_model > MAX_NODES) ? MAX_NODES : node_count_model;
    rows_used = (n_eff == 0) ? 1 : n_eff;
    mode = $urandom_range(3);
    for (int i = 0; i < MAX_NODES; i++) order[i] = i;
    for (int i = MAX_NODES - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < MAX_NODES; i++) rank[order[i]] = i;
    cnt = 0;
    if (mode <= 1) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        r = order[i];
        if (r < rows_used || $urandom_range(7) == 0) begin
          mask = '0;
          for (int v = 0; v < MAX_NODES; v++) if (rank[v] > rank[r]) mask[v] = 1'b1;
          edges = ROW_W'($urandom_range(1) ? $urandom : ($urandom & $urandom)) & mask;
          if (mode == 1 && $urandom_range(3) == 0) edges[order[$urandom_range(i)]] = 1'b1;
          rows[cnt] = {r[ROW_IDX_W-1:0], edges, 1'b0};
          cnt++;
        end
      end
    end else begin
      tmp = $urandom_range(3, 1);
      for (int i = 0; i < tmp; i++) begin
        r = $urandom_range(3) == 0 ? $urandom_range(MAX_NODES - 1) : $urandom_range(rows_used - 1);
        edges = ROW_W'((mode == 2) ? ($urandom & $urandom & $urandom) : $urandom);
        rows[cnt] = {r[ROW_IDX_W-1:0], edges, 1'b0};
        cnt++;
      end
    end
    rows[cnt-1].last = 1'b1;
    for (int i = 0; i < cnt; i++) row_q.push_back(rows[i]);
    pushed = cnt;
  endtask

  // Waits until every request is taken and every result has arrived, then lets the block settle.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (row_q.size() != 0 || in_valid_i || cycle_flag_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [CNT_IN_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_node_count_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i      <= 1'b0;
    node_count_model = value;
  endtask

  // Driver: offers queued row requests and predicts the outcome of each accepted last row.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        adj_model[row_index_i] = row_edges_i;
        if (last_row_i) cycle_flag_q.push_back(predict_cycle());
      end
      if (!in_valid_i || in_ready_o) begin
        if (row_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          row_req_t req;
          req = row_q.pop_front();
          row_index_i <= req.row;
          row_edges_i <= req.edges;
          last_row_i  <= req.last;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (cycle_flag_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, has_cycle=%0b", has_cycle_o));
        end else begin
          logic exp_flag;
          exp_flag = cycle_flag_q.pop_front();
          if (has_cycle_o !== exp_flag)
            report_mismatch($sformatf("has_cycle: expected %0b, got %0b", exp_flag, has_cycle_o));
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so that the block backs up onto its input.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus: directed graphs, then random phases over several node counts and idling modes.
  initial begin
    int unsigned n_items;
    int unsigned pushed;
    int          nc;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A chain through all sixteen nodes writes every row and reaches full stack depth.
    for (int i = 0; i < MAX_NODES - 1; i++) push_row(i, 16'h1 << (i + 1), 1'b0);
    push_row(15, 16'h0000, 1'b1);
    // Closing the chain gives a cycle through every node.
    push_row(15, 16'h0001, 1'b1);
    // A full row includes a self-loop.
    push_row(15, 16'hFFFF, 1'b1);
    push_row(15, 16'h0000, 1'b1);
    // Self-loop in the middle of the chain.
    push_row(7, 16'h0180, 1'b1);
    push_row(7, 16'h0100, 1'b0);
    push_row(0, 16'h0000, 1'b1);
    wait_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      nc = (nc_plan[p] < 0) ? $urandom_range(15, 2) : nc_plan[p];
      if (p != 0) write_node_count(nc[CNT_IN_W-1:0]);
      @(negedge clk_i);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        push_graph(pushed);
        n_items += pushed;
      end
      wait_quiet();
    end

    // Back-pressure: graphs over all sixteen nodes offered without gaps while the receiver holds off.
    write_node_count(5'd16);
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int g = 0; g < 4; g++) push_graph(pushed);
    pressure_go = 1'b1;
    wait_quiet();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dcd_pkg.sv
rtl/dcd_adj_store.sv
rtl/dcd_walker.sv
rtl/directed_cycle_detect.sv
rtl/dcd_checker.sv
tb/tb_top.sv
